FILE: rtl/kor_pkg.sv
package kor_pkg;

    localparam int SLOTS     = 16;
    localparam int PTR_W     = $clog2(SLOTS);
    localparam int ZONE_W    = 6;
    localparam int PAYLOAD_W = 32;
    localparam int REC_W     = ZONE_W + PAYLOAD_W;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND   = 3'd0,
        MODE_UPDATE   = 3'd1,
        MODE_DELETE   = 3'd2,
        MODE_READ_ALL = 3'd3,
        MODE_CLEAR    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_UPD,
        S_WALK_UPD,
        S_FETCH_RD,
        S_WALK_RD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    append;
        logic    drop;
        logic    clear;
        logic    load;
        logic    step;
        logic    upd_write;
        logic    emit;
        logic    emit_rec;
        logic    emit_last;
        status_t emit_status;
    } kor_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic match;
        logic at_end;
    } kor_stat_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

FILE: rtl/keyed_overwrite_ring_log.sv
// Channel  | Signals                                          | Handshake
// ---------+--------------------------------------------------+---------------------------
// command  | start, busy, mode, zone, payload                 | taken when start && !busy
// result   | strobe, out_zone, out_payload, entry_valid,      | one item per strobe cycle,
//          | last, status                                     | no back-pressure
//
// Append, delete, clear, unused modes and every command on an empty log finish in
// the accept cycle; the single result appears in the next cycle and busy stays low.
// Update and read-all walk the record store through its one registered read port,
// one stored record per cycle after a fetch state.
// Reset (rst_n low, asynchronous) empties the log; the store itself is not cleared.
// The receiver cannot stall, so a result is always delivered in the cycle it appears.
module keyed_overwrite_ring_log
    import kor_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ZONE_W-1:0]    zone,
    input  logic [PAYLOAD_W-1:0] payload,
    output logic                 strobe,
    output logic [ZONE_W-1:0]    out_zone,
    output logic [PAYLOAD_W-1:0] out_payload,
    output logic                 entry_valid,
    output logic                 last,
    output logic [STATUS_W-1:0]  status
);

    kor_cmd_t  cmd;
    kor_stat_t stat;

    // The controller sequences each item; the datapath holds the ring
    // pointers, the record store and the result registers.
    kor_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    kor_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .zone        (zone),
        .payload     (payload),
        .strobe      (strobe),
        .out_zone    (out_zone),
        .out_payload (out_payload),
        .entry_valid (entry_valid),
        .last        (last),
        .status      (status)
    );

endmodule

FILE: rtl/kor_ram.sv
module kor_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/kor_datapath.sv
module kor_datapath
    import kor_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kor_cmd_t             cmd,
    output kor_stat_t            stat,
    input  logic [ZONE_W-1:0]    zone,
    input  logic [PAYLOAD_W-1:0] payload,
    output logic                 strobe,
    output logic [ZONE_W-1:0]    out_zone,
    output logic [PAYLOAD_W-1:0] out_payload,
    output logic                 entry_valid,
    output logic                 last,
    output logic [STATUS_W-1:0]  status
);

    logic [PTR_W-1:0]     oldest_reg, oldest_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [PTR_W-1:0]     scan_reg, scan_next;
    logic [PTR_W-1:0]     rd_reg, rd_next;
    logic [ZONE_W-1:0]    key_zone_reg;
    logic [PAYLOAD_W-1:0] key_payload_reg;
    logic                 strobe_reg;
    logic [ZONE_W-1:0]    out_zone_reg;
    logic [PAYLOAD_W-1:0] out_payload_reg;
    logic                 entry_valid_reg;
    logic                 last_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [REC_W-1:0]     ram_wdata;
    logic [REC_W-1:0]     ram_rdata;
    logic [PTR_W-1:0]     tail_adv;

    kor_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    assign ram_we    = cmd.append | cmd.upd_write;
    assign ram_waddr = cmd.append ? tail_reg : rd_reg;
    assign ram_wdata = cmd.append ? {zone, payload} : {key_zone_reg, key_payload_reg};

    assign stat.empty  = (oldest_reg == tail_reg);
    assign stat.match  = (ram_rdata[REC_W-1 -: ZONE_W] == key_zone_reg);
    assign stat.at_end = (ring_next(rd_reg) == tail_reg);

    assign tail_adv = ring_next(tail_reg);

    always_comb
    begin
        oldest_next = oldest_reg;
        tail_next   = tail_reg;
        scan_next   = scan_reg;
        rd_next     = rd_reg;
        if (cmd.append)
        begin
            tail_next = tail_adv;
            if (tail_adv == oldest_reg)
            begin
                oldest_next = ring_next(oldest_reg);
            end
        end
        if (cmd.drop)
        begin
            oldest_next = ring_next(oldest_reg);
        end
        if (cmd.clear)
        begin
            oldest_next = tail_reg;
        end
        if (cmd.load)
        begin
            scan_next = oldest_reg;
        end
        if (cmd.step)
        begin
            scan_next = ring_next(scan_reg);
            rd_next   = scan_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            tail_reg   <= '0;
            scan_reg   <= '0;
            rd_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            tail_reg   <= tail_next;
            scan_reg   <= scan_next;
            rd_reg     <= rd_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_zone_reg    <= zone;
            key_payload_reg <= payload;
        end
        if (cmd.emit)
        begin
            out_zone_reg    <= cmd.emit_rec ? ram_rdata[REC_W-1 -: ZONE_W] : '0;
            out_payload_reg <= cmd.emit_rec ? ram_rdata[PAYLOAD_W-1:0] : '0;
            entry_valid_reg <= cmd.emit_rec;
            last_reg        <= cmd.emit_last;
            status_reg      <= cmd.emit_status;
        end
    end

    assign strobe      = strobe_reg;
    assign out_zone    = out_zone_reg;
    assign out_payload = out_payload_reg;
    assign entry_valid = entry_valid_reg;
    assign last        = last_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_append_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> !stat.empty)
        else $error("log empty right after an append");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> stat.empty)
        else $error("log not empty right after a clear");

    a_drop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |=> oldest_reg == ring_next($past(oldest_reg)))
        else $error("delete did not advance the oldest pointer by one");

    a_record_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && entry_valid_reg |-> status_reg == STAT_OK)
        else $error("emitted record carries a non-zero status");
`endif

endmodule

FILE: rtl/kor_ctrl.sv
module kor_ctrl
    import kor_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  kor_stat_t         stat,
    output kor_cmd_t          cmd,
    output logic              busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = STAT_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    case (mode_t'(mode))
                        MODE_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        MODE_UPDATE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.emit   = 1'b0;
                                cmd.load   = 1'b1;
                                state_next = S_FETCH_UPD;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.drop = 1'b1;
                            end
                        end
                        MODE_READ_ALL:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.emit   = 1'b0;
                                cmd.load   = 1'b1;
                                state_next = S_FETCH_RD;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH_UPD:
            begin
                cmd.step   = 1'b1;
                state_next = S_WALK_UPD;
            end
            S_WALK_UPD:
            begin
                if (stat.match)
                begin
                    cmd.upd_write = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.at_end)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = STAT_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FETCH_RD:
            begin
                cmd.step   = 1'b1;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_rec  = 1'b1;
                cmd.emit_last = stat.at_end;
                if (stat.at_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef NO_ASSERTIONS
    a_walk_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH_RD) |=> (state_reg == S_WALK_RD))
        else $error("read walk did not follow its first fetch");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_RD) |-> !cmd.upd_write && !cmd.append)
        else $error("log written during a read-all walk");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.emit_last |=> !busy)
        else $error("block still busy after the final result of an item");
`endif

endmodule
